/* rtl/core/spc_pkg.sv */
`default_nettype none
package spc_pkg;

    localparam int TimerBits = 16;

    typedef logic [TimerBits-1:0] t_timer;

    typedef enum logic [3:0] {
        OP_TICK = 4'd0, OP_PING = 4'd1, OP_CENTER = 4'd2, OP_STOP = 4'd3,
        OP_ANGLE = 4'd4, OP_LED = 4'd5, OP_MODE = 4'd6, OP_BUZZ_ON = 4'd7,
        OP_BUZZ_OFF = 4'd8, OP_BEEP = 4'd9, OP_STATUS = 4'd10, OP_INVALID = 4'd11
    } t_op;

    typedef enum logic [3:0] {
        CL_TICK, CL_PING, CL_CENTER, CL_STOP, CL_ANGLE_OK, CL_ANGLE_BAD, CL_LED,
        CL_MODE, CL_BUZZ_ON, CL_BUZZ_OFF, CL_BEEP, CL_STATUS, CL_INVALID
    } t_class;

    localparam logic [2:0] RC_TICK = 3'd0, RC_PONG = 3'd1, RC_OK = 3'd2, RC_OK_DEPR = 3'd3,
                           RC_BAD_ANGLE = 3'd4, RC_BAD_CMD = 3'd5, RC_STATUS = 3'd6;

    localparam logic [3:0] LC_PING = 4'd1, LC_CENTER = 4'd2, LC_STOP = 4'd3,
                           LC_ANGLE = 4'd4, LC_LED = 4'd5, LC_STATE = 4'd6,
                           LC_BUZZER = 4'd7, LC_INVALID = 4'd8;

    localparam logic [3:0] LR_PONG = 4'd1, LR_CENTER = 4'd2, LR_STOP = 4'd3,
                           LR_ANGLE = 4'd4, LR_BAD_ANGLE = 4'd5, LR_LED = 4'd6,
                           LR_STATE = 4'd7, LR_BUZZ_ON = 4'd8, LR_BUZZ_OFF = 4'd9,
                           LR_BEEP = 4'd10, LR_BAD_CMD = 4'd11;

    localparam logic [1:0] MODE_IDLE = 2'd0, MODE_SEARCH = 2'd1, MODE_LOCK = 2'd2,
                           MODE_LOST = 2'd3;

    localparam logic [2:0] REG_MIN = 3'd0, REG_MAX = 3'd1, REG_CENTER = 3'd2,
                           REG_STEP = 3'd3, REG_STEP_INT = 3'd4, REG_BLINK = 3'd5,
                           REG_BEEP = 3'd6, REG_GAP = 3'd7;

    // Classified command as it travels through the queue.
    typedef struct packed {
        t_class     cls;
        logic [7:0] angle;
        logic [1:0] mode;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  min_angle;
        logic [7:0]  max_angle;
        logic [7:0]  center_angle;
        logic [7:0]  step_degrees;
        logic [15:0] step_interval_ms;
        logic [15:0] blink_interval_ms;
        logic [15:0] beep_ms;
        logic [15:0] gap_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0] result_code;
        logic [7:0] current_angle_out;
        logic [7:0] target_angle_out;
        logic       servo_enabled;
        logic       green_led;
        logic       red_led;
        logic       buzzer_active;
        logic [1:0] mode_out;
        logic [3:0] last_command_code;
        logic [3:0] last_result_code;
    } t_res;

    // Saturating timer increment.
    function automatic t_timer tmr_inc(input t_timer t);
        t_timer r;
        r = (t == '1) ? t : t + 1'b1;
        return r;
    endfunction

    // Timer value compared with a 16-bit interval register.
    function automatic logic tmr_reached(input t_timer t, input logic [15:0] lim);
        logic [TimerBits+15:0] a;
        logic [TimerBits+15:0] b;
        a = (TimerBits+16)'(t);
        b = (TimerBits+16)'(lim);
        return a >= b;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/spc_in_if.sv */
`default_nettype none
interface spc_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         op;
    logic signed [15:0] angle_request;
    logic [1:0]         mode_request;
    modport source (output valid, op, angle_request, mode_request, input ready);
    modport sink (input valid, op, angle_request, mode_request, output ready);
endinterface
`default_nettype wire

/* rtl/core/spc_out_if.sv */
`default_nettype none
interface spc_out_if
    import spc_pkg::*;
;
    logic valid;
    logic ready;
    t_res res;
    modport source (output valid, res, input ready);
    modport sink (input valid, res, output ready);
endinterface
`default_nettype wire

/* rtl/core/spc_front.sv */
`default_nettype none
module spc_front
    import spc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [3:0]         i_op,
    input  wire logic signed [15:0] i_angle_request,
    input  wire logic [1:0]         i_mode_request,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_cmd                    o_cmd
);
    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic signed [16:0] req;
    logic signed [16:0] lo;
    logic signed [16:0] hi;

    assign o_ready = !r_valid || i_ready;

    // Classify the op and range-check an angle request.
    always_comb begin
        req = 17'(i_angle_request);
        lo  = $signed({9'd0, i_cfg.min_angle});
        hi  = $signed({9'd0, i_cfg.max_angle});
        n_cmd.angle = i_angle_request[7:0];
        n_cmd.mode  = i_mode_request;
        unique case (i_op)
            OP_TICK:     n_cmd.cls = CL_TICK;
            OP_PING:     n_cmd.cls = CL_PING;
            OP_CENTER:   n_cmd.cls = CL_CENTER;
            OP_STOP:     n_cmd.cls = CL_STOP;
            OP_ANGLE:    n_cmd.cls = (req < lo || req > hi) ? CL_ANGLE_BAD : CL_ANGLE_OK;
            OP_LED:      n_cmd.cls = CL_LED;
            OP_MODE:     n_cmd.cls = CL_MODE;
            OP_BUZZ_ON:  n_cmd.cls = CL_BUZZ_ON;
            OP_BUZZ_OFF: n_cmd.cls = CL_BUZZ_OFF;
            OP_BEEP:     n_cmd.cls = CL_BEEP;
            OP_STATUS:   n_cmd.cls = CL_STATUS;
            default:     n_cmd.cls = CL_INVALID;
        endcase
    end

    // Single queue slot between the front and the back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;
endmodule
`default_nettype wire

/* rtl/core/spc_back.sv */
`default_nettype none
module spc_back
    import spc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_res      o_res
);
    logic [7:0] r_cur, n_cur, r_tgt, n_tgt;
    logic       r_att, n_att;
    t_timer     r_stmr, n_stmr, r_btmr, n_btmr, r_ztmr, n_ztmr;
    logic [1:0] r_mode, n_mode, r_beeps, n_beeps;
    logic       r_phase, n_phase, r_on, n_on, r_hold, n_hold, r_started, n_started;
    logic [3:0] r_lcmd, n_lcmd, r_lres, n_lres;
    logic [2:0] rc;
    logic       r_valid;
    t_res       r_res;
    logic       go;
    t_timer     e;
    logic [8:0] nxt;
    logic [7:0] cl;

    assign o_ready = !r_valid || i_ready;
    assign go = i_valid && o_ready;

    // Carry out one item on the state registers.
    always_comb begin
        n_cur = r_cur; n_tgt = r_tgt; n_att = r_att; n_stmr = r_stmr;
        n_btmr = r_btmr; n_ztmr = r_ztmr; n_mode = r_mode; n_beeps = r_beeps;
        n_phase = r_phase; n_on = r_on; n_hold = r_hold; n_started = r_started;
        n_lcmd = r_lcmd; n_lres = r_lres; rc = RC_TICK;
        e = '0; nxt = '0; cl = '0;
        unique case (i_cmd.cls)
            CL_TICK: begin
                // Servo slew.
                e = tmr_inc(r_stmr);
                if (!tmr_reached(e, i_cfg.step_interval_ms)) begin
                    n_stmr = e;
                end else begin
                    n_stmr = '0;
                    if (r_cur != r_tgt) begin
                        if (r_tgt > r_cur) begin
                            nxt = {1'b0, r_cur} + {1'b0, i_cfg.step_degrees};
                            if (nxt > {1'b0, r_tgt}) nxt = {1'b0, r_tgt};
                        end else begin
                            nxt = {1'b0, r_cur} - {1'b0, i_cfg.step_degrees};
                            if (i_cfg.step_degrees > r_cur - r_tgt) nxt = {1'b0, r_tgt};
                        end
                        if (nxt < {1'b0, i_cfg.min_angle}) cl = i_cfg.min_angle;
                        else if (nxt > {1'b0, i_cfg.max_angle}) cl = i_cfg.max_angle;
                        else cl = nxt[7:0];
                        n_att = 1'b1;
                        n_cur = cl;
                    end
                end
                // Search blink.
                e = tmr_inc(r_btmr);
                if (r_mode == MODE_SEARCH && tmr_reached(e, i_cfg.blink_interval_ms)) begin
                    n_btmr = '0;
                    n_phase = !r_phase;
                end else begin
                    n_btmr = e;
                end
                // Buzzer pattern.
                e = tmr_inc(r_ztmr);
                n_ztmr = e;
                if (!r_hold && (r_beeps != 2'd0 || r_on)) begin
                    if (r_on) begin
                        if (tmr_reached(e, i_cfg.beep_ms)) begin
                            n_on = 1'b0;
                            if (r_beeps != 2'd0) n_beeps = r_beeps - 2'd1;
                            n_started = 1'b1;
                            n_ztmr = '0;
                        end
                    end else if (!(r_started && !tmr_reached(e, i_cfg.gap_ms))) begin
                        n_on = 1'b1;
                        n_started = 1'b1;
                        n_ztmr = '0;
                    end
                end
                rc = RC_TICK;
            end
            CL_PING: begin
                n_lcmd = LC_PING; n_lres = LR_PONG; rc = RC_PONG;
            end
            CL_CENTER: begin
                if (i_cfg.center_angle < i_cfg.min_angle) n_tgt = i_cfg.min_angle;
                else if (i_cfg.center_angle > i_cfg.max_angle) n_tgt = i_cfg.max_angle;
                else n_tgt = i_cfg.center_angle;
                n_lcmd = LC_CENTER; n_lres = LR_CENTER; rc = RC_OK;
            end
            CL_STOP: begin
                if (r_cur < i_cfg.min_angle) n_tgt = i_cfg.min_angle;
                else if (r_cur > i_cfg.max_angle) n_tgt = i_cfg.max_angle;
                else n_tgt = r_cur;
                n_lcmd = LC_STOP; n_lres = LR_STOP; rc = RC_OK;
            end
            CL_ANGLE_OK: begin
                n_tgt = i_cmd.angle;
                n_lcmd = LC_ANGLE; n_lres = LR_ANGLE; rc = RC_OK;
            end
            CL_ANGLE_BAD: begin
                n_lcmd = LC_ANGLE; n_lres = LR_BAD_ANGLE; rc = RC_BAD_ANGLE;
            end
            CL_LED: begin
                n_lcmd = LC_LED; n_lres = LR_LED; rc = RC_OK_DEPR;
            end
            CL_MODE: begin
                if (i_cmd.mode != r_mode) begin
                    n_btmr = '0;
                    n_phase = 1'b1;
                end
                n_mode = i_cmd.mode;
                n_beeps = (i_cmd.mode == MODE_LOCK) ? 2'd1 :
                          (i_cmd.mode == MODE_LOST) ? 2'd2 : 2'd0;
                n_on = 1'b0; n_hold = 1'b0; n_started = 1'b0; n_ztmr = '0;
                n_lcmd = LC_STATE; n_lres = LR_STATE; rc = RC_OK;
            end
            CL_BUZZ_ON: begin
                n_beeps = 2'd0; n_on = 1'b1; n_hold = 1'b1; n_started = 1'b1; n_ztmr = '0;
                n_lcmd = LC_BUZZER; n_lres = LR_BUZZ_ON; rc = RC_OK;
            end
            CL_BUZZ_OFF: begin
                n_beeps = 2'd0; n_on = 1'b0; n_hold = 1'b0; n_started = 1'b0; n_ztmr = '0;
                n_lcmd = LC_BUZZER; n_lres = LR_BUZZ_OFF; rc = RC_OK;
            end
            CL_BEEP: begin
                n_beeps = 2'd1; n_on = 1'b0; n_hold = 1'b0; n_started = 1'b0; n_ztmr = '0;
                n_lcmd = LC_BUZZER; n_lres = LR_BEEP; rc = RC_OK;
            end
            CL_STATUS: begin
                rc = RC_STATUS;
            end
            default: begin
                n_lcmd = LC_INVALID; n_lres = LR_BAD_CMD; rc = RC_BAD_CMD;
            end
        endcase
    end

    // State and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= 8'd90; r_tgt <= 8'd90; r_att <= 1'b0;
            r_stmr <= '0; r_btmr <= '0; r_ztmr <= '0;
            r_mode <= MODE_IDLE; r_beeps <= 2'd0; r_phase <= 1'b1;
            r_on <= 1'b0; r_hold <= 1'b0; r_started <= 1'b0;
            r_lcmd <= '0; r_lres <= '0; r_valid <= 1'b0;
        end else begin
            if (o_ready) r_valid <= i_valid;
            if (go) begin
                r_cur <= n_cur; r_tgt <= n_tgt; r_att <= n_att;
                r_stmr <= n_stmr; r_btmr <= n_btmr; r_ztmr <= n_ztmr;
                r_mode <= n_mode; r_beeps <= n_beeps; r_phase <= n_phase;
                r_on <= n_on; r_hold <= n_hold; r_started <= n_started;
                r_lcmd <= n_lcmd; r_lres <= n_lres;
            end
        end
        if (go) begin
            r_res.result_code       <= rc;
            r_res.current_angle_out <= n_cur;
            r_res.target_angle_out  <= n_tgt;
            r_res.servo_enabled     <= n_att;
            r_res.green_led         <= (n_mode == MODE_SEARCH) ? n_phase :
                                       (n_mode == MODE_LOCK);
            r_res.red_led           <= (n_mode == MODE_LOST);
            r_res.buzzer_active     <= n_on;
            r_res.mode_out          <= n_mode;
            r_res.last_command_code <= n_lcmd;
            r_res.last_result_code  <= n_lres;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule
`default_nettype wire

/* rtl/core/servo_pointer_controller_top.sv */
// An accepted item waits in the single-slot command queue, then its result
// is taken into the result register; back-pressure can stall either of them.
// Throughput: one item per cycle when not stalled; the command queue and
// the result register let the front and the back stall independently.
// Reset: synchronous, active low; clears the queue and result valid flags,
// all state to its power-up values and the configuration to its defaults.
`default_nettype none
module servo_pointer_controller_top
    import spc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    spc_in_if.sink     in_ch,
    spc_out_if.source  out_ch
);
    t_cfg r_cfg;
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{min_angle: 8'd0, max_angle: 8'd180, center_angle: 8'd90,
                       step_degrees: 8'd1, step_interval_ms: 16'd15,
                       blink_interval_ms: 16'd250, beep_ms: 16'd100, gap_ms: 16'd100};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MIN:      r_cfg.min_angle         <= i_cfg_data[7:0];
                REG_MAX:      r_cfg.max_angle         <= i_cfg_data[7:0];
                REG_CENTER:   r_cfg.center_angle      <= i_cfg_data[7:0];
                REG_STEP:     r_cfg.step_degrees      <= i_cfg_data[7:0];
                REG_STEP_INT: r_cfg.step_interval_ms  <= i_cfg_data;
                REG_BLINK:    r_cfg.blink_interval_ms <= i_cfg_data;
                REG_BEEP:     r_cfg.beep_ms           <= i_cfg_data;
                REG_GAP:      r_cfg.gap_ms            <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    spc_front u_front (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_valid(in_ch.valid), .o_ready(in_ch.ready), .i_op(in_ch.op),
        .i_angle_request(in_ch.angle_request), .i_mode_request(in_ch.mode_request),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    spc_back u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_res(out_ch.res)
    );

    // A held result must not change while it waits.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.res))
        else $error("result changed while stalled");
    // The red and green LEDs are never lit together.
    a_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !(out_ch.res.red_led && out_ch.res.green_led))
        else $error("both LEDs lit");
    // Every result carries a defined result code.
    a_rc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> out_ch.res.result_code <= RC_STATUS)
        else $error("result code out of range");
endmodule
`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none
module tb_top;
    import spc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Pending input item.
    typedef struct {
        logic [3:0]         op;
        logic signed [15:0] angle_req;
        logic [1:0]         mode_req;
    } t_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    spc_in_if  in_ch();
    spc_out_if out_ch();

    servo_pointer_controller_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    // Shadow copy of the configuration and state.
    t_cfg        cfg;
    logic [7:0]  cur_ang, tgt_ang;
    logic        attached, blink_ph, bz_on, bz_hold, ph_started;
    logic [1:0]  mode_q, beeps;
    t_timer      step_tmr, blink_tmr, bz_tmr;
    logic [3:0]  last_cmd, last_res;

    t_item  pending_items[$];
    t_res   expected_snapshots[$];
    int     mismatches;
    int     idle_cycles;
    int     in_wait, out_wait;
    logic   hold_sender;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [7:0] limit_angle(input int a);
        if (a < int'(cfg.min_angle)) return cfg.min_angle;
        if (a > int'(cfg.max_angle)) return cfg.max_angle;
        return a[7:0];
    endfunction

    function automatic t_timer sat_inc(input t_timer t);
        if (t == '1) return t;
        return t + 1'b1;
    endfunction

    function automatic void restart_pattern(input logic [1:0] n);
        beeps = n;
        bz_on = 1'b0;
        bz_hold = 1'b0;
        ph_started = 1'b0;
        bz_tmr = '0;
    endfunction

    task automatic reset_shadow();
        cfg = '{8'd0, 8'd180, 8'd90, 8'd1, 16'd15, 16'd250, 16'd100, 16'd100};
        cur_ang = 8'd90;
        tgt_ang = 8'd90;
        attached = 1'b0;
        step_tmr = '0;
        mode_q = MODE_IDLE;
        blink_ph = 1'b1;
        blink_tmr = '0;
        restart_pattern(2'd0);
        last_cmd = 4'd0;
        last_res = 4'd0;
    endtask

    // One tick: servo slew, LED blink, then the buzzer pattern.
    function automatic void advance_tick();
        t_timer e;
        int     nxt;
        e = sat_inc(step_tmr);
        if (e < cfg.step_interval_ms) begin
            step_tmr = e;
        end else begin
            step_tmr = '0;
            if (cur_ang != tgt_ang) begin
                if (tgt_ang > cur_ang) begin
                    nxt = int'(cur_ang) + int'(cfg.step_degrees);
                    if (nxt > int'(tgt_ang)) nxt = int'(tgt_ang);
                end else begin
                    nxt = int'(cur_ang) - int'(cfg.step_degrees);
                    if (nxt < int'(tgt_ang)) nxt = int'(tgt_ang);
                end
                attached = 1'b1;
                cur_ang = limit_angle(nxt);
            end
        end
        e = sat_inc(blink_tmr);
        if (mode_q != MODE_SEARCH) begin
            blink_tmr = e;
        end else if (e >= cfg.blink_interval_ms) begin
            blink_tmr = '0;
            blink_ph = ~blink_ph;
        end else begin
            blink_tmr = e;
        end
        e = sat_inc(bz_tmr);
        bz_tmr = e;
        if (!bz_hold && !(beeps == 0 && !bz_on)) begin
            if (bz_on) begin
                if (e >= cfg.beep_ms) begin
                    bz_on = 1'b0;
                    if (beeps > 0) beeps = beeps - 1'b1;
                    ph_started = 1'b1;
                    bz_tmr = '0;
                end
            end else if (!(ph_started && e < cfg.gap_ms)) begin
                bz_on = 1'b1;
                ph_started = 1'b1;
                bz_tmr = '0;
            end
        end
    endfunction

    // Applies one item to the shadow state and returns the snapshot after it.
    function automatic t_res predict_snapshot(input t_item it);
        t_res r;
        int   req;
        req = it.angle_req;
        r = '0;
        case (it.op)
            OP_TICK: begin
                advance_tick();
                r.result_code = RC_TICK;
            end
            OP_PING: begin
                last_cmd = LC_PING; last_res = LR_PONG; r.result_code = RC_PONG;
            end
            OP_CENTER: begin
                tgt_ang = limit_angle(int'(cfg.center_angle));
                last_cmd = LC_CENTER; last_res = LR_CENTER; r.result_code = RC_OK;
            end
            OP_STOP: begin
                tgt_ang = limit_angle(int'(cur_ang));
                last_cmd = LC_STOP; last_res = LR_STOP; r.result_code = RC_OK;
            end
            OP_ANGLE: begin
                last_cmd = LC_ANGLE;
                if (req < int'(cfg.min_angle) || req > int'(cfg.max_angle)) begin
                    last_res = LR_BAD_ANGLE; r.result_code = RC_BAD_ANGLE;
                end else begin
                    tgt_ang = limit_angle(req);
                    last_res = LR_ANGLE; r.result_code = RC_OK;
                end
            end
            OP_LED: begin
                last_cmd = LC_LED; last_res = LR_LED; r.result_code = RC_OK_DEPR;
            end
            OP_MODE: begin
                if (it.mode_req != mode_q) begin
                    blink_tmr = '0;
                    blink_ph = 1'b1;
                end
                mode_q = it.mode_req;
                if (it.mode_req == MODE_LOCK) restart_pattern(2'd1);
                else if (it.mode_req == MODE_LOST) restart_pattern(2'd2);
                else restart_pattern(2'd0);
                last_cmd = LC_STATE; last_res = LR_STATE; r.result_code = RC_OK;
            end
            OP_BUZZ_ON: begin
                beeps = 2'd0; bz_on = 1'b1; bz_hold = 1'b1;
                ph_started = 1'b1; bz_tmr = '0;
                last_cmd = LC_BUZZER; last_res = LR_BUZZ_ON; r.result_code = RC_OK;
            end
            OP_BUZZ_OFF: begin
                restart_pattern(2'd0);
                last_cmd = LC_BUZZER; last_res = LR_BUZZ_OFF; r.result_code = RC_OK;
            end
            OP_BEEP: begin
                restart_pattern(2'd1);
                last_cmd = LC_BUZZER; last_res = LR_BEEP; r.result_code = RC_OK;
            end
            OP_STATUS: r.result_code = RC_STATUS;
            default: begin
                last_cmd = LC_INVALID; last_res = LR_BAD_CMD; r.result_code = RC_BAD_CMD;
            end
        endcase
        r.current_angle_out = cur_ang;
        r.target_angle_out = tgt_ang;
        r.servo_enabled = attached;
        r.green_led = (mode_q == MODE_SEARCH) ? blink_ph : (mode_q == MODE_LOCK);
        r.red_led = (mode_q == MODE_LOST);
        r.buzzer_active = bz_on;
        r.mode_out = mode_q;
        r.last_command_code = last_cmd;
        r.last_result_code = last_res;
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
    endtask

    // Driver: presents queued items with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_wait <= 0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // Hold the item until it is taken.
        end else if (in_wait > 0) begin
            in_ch.valid <= 1'b0;
            in_wait <= in_wait - 1;
        end else if (pending_items.size() > 0 && !hold_sender) begin
            t_item it;
            it = pending_items.pop_front();
            in_ch.valid <= 1'b1;
            in_ch.op <= it.op;
            in_ch.angle_request <= it.angle_req;
            in_ch.mode_request <= it.mode_req;
            expected_snapshots.push_back(predict_snapshot(it));
            in_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Monitor: random back-pressure, then field-by-field comparison.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_wait <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_snapshots.size() == 0) begin
                    report("unexpected item", 1, 0);
                end else begin
                    t_res w, g;
                    w = expected_snapshots.pop_front();
                    g = out_ch.res;
                    if (g.result_code !== w.result_code)
                        report("result_code", g.result_code, w.result_code);
                    if (g.current_angle_out !== w.current_angle_out)
                        report("current_angle", g.current_angle_out, w.current_angle_out);
                    if (g.target_angle_out !== w.target_angle_out)
                        report("target_angle", g.target_angle_out, w.target_angle_out);
                    if (g.servo_enabled !== w.servo_enabled)
                        report("servo_enabled", g.servo_enabled, w.servo_enabled);
                    if (g.green_led !== w.green_led)
                        report("green_led", g.green_led, w.green_led);
                    if (g.red_led !== w.red_led)
                        report("red_led", g.red_led, w.red_led);
                    if (g.buzzer_active !== w.buzzer_active)
                        report("buzzer_active", g.buzzer_active, w.buzzer_active);
                    if (g.mode_out !== w.mode_out)
                        report("mode", g.mode_out, w.mode_out);
                    if (g.last_command_code !== w.last_command_code)
                        report("last_command", g.last_command_code, w.last_command_code);
                    if (g.last_result_code !== w.last_result_code)
                        report("last_result", g.last_result_code, w.last_result_code);
                end
                out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                out_ch.ready <= 1'b0;
            end else if (out_wait > 0) begin
                out_wait <= out_wait - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_item(input logic [3:0] op, input int ang, input logic [1:0] m);
        t_item it;
        it.op = op;
        it.angle_req = ang[15:0];
        it.mode_req = m;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_snapshots.size() > 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    // Register writes happen only while nothing is in flight.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MIN:      cfg.min_angle = val[7:0];
            REG_MAX:      cfg.max_angle = val[7:0];
            REG_CENTER:   cfg.center_angle = val[7:0];
            REG_STEP:     cfg.step_degrees = val[7:0];
            REG_STEP_INT: cfg.step_interval_ms = val;
            REG_BLINK:    cfg.blink_interval_ms = val;
            REG_BEEP:     cfg.beep_ms = val;
            REG_GAP:      cfg.gap_ms = val;
            default:      ;
        endcase
    endtask

    // Random angle: mostly in the useful range, sometimes anywhere.
    function automatic int rand_angle();
        case ($urandom_range(0, 5))
            0:       return $signed(16'($urandom));
            1:       return $urandom_range(181, 260);
            default: return $urandom_range(0, 180);
        endcase
    endfunction

    // Random phase: ticks dominate so that the timers run out.
    task automatic random_phase(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 6)
                push_item(OP_TICK, $signed(16'($urandom)), 2'($urandom));
            else
                push_item(4'($urandom_range(1, 15)), rand_angle(), 2'($urandom));
        end
    endtask

    initial begin
        mismatches = 0;
        hold_sender = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_MIN;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_TICK;
        in_ch.angle_request = '0;
        in_ch.mode_request = MODE_IDLE;
        out_ch.ready = 1'b0;
        reset_shadow();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every command, angle extremes, unused codes, status.
        push_item(OP_PING, 0, MODE_IDLE);
        push_item(OP_ANGLE, -32768, MODE_IDLE);
        push_item(OP_ANGLE, 32767, MODE_IDLE);
        push_item(OP_ANGLE, 181, MODE_IDLE);
        push_item(OP_ANGLE, 0, MODE_IDLE);
        push_item(OP_STATUS, -1, MODE_LOST);
        for (int k = 0; k < 6; k++) push_item(OP_TICK, 0, MODE_IDLE);
        push_item(OP_STOP, 0, MODE_IDLE);
        push_item(OP_CENTER, 0, MODE_IDLE);
        push_item(OP_LED, 0, MODE_IDLE);
        push_item(OP_MODE, 0, MODE_SEARCH);
        push_item(OP_MODE, 0, MODE_LOCK);
        push_item(OP_MODE, 0, MODE_LOST);
        push_item(OP_BUZZ_ON, 0, MODE_IDLE);
        push_item(OP_BUZZ_OFF, 0, MODE_IDLE);
        push_item(OP_BEEP, 0, MODE_IDLE);
        push_item(OP_INVALID, 0, MODE_IDLE);
        push_item(4'd15, 180, MODE_IDLE);
        push_item(4'd12, 0, MODE_IDLE);

        // Short intervals so that slews, blinks and beeps happen often.
        hold_sender = 1'b1;
        write_reg(REG_STEP_INT, 16'd2);
        write_reg(REG_BLINK, 16'd3);
        write_reg(REG_BEEP, 16'd2);
        write_reg(REG_GAP, 16'd3);
        write_reg(REG_STEP, 16'd7);
        hold_sender = 1'b0;
        wait_drained();
        random_phase(350);
        wait_drained();

        // Extremes: zero intervals, inverted range, full step.
        write_reg(REG_MIN, 16'd180);
        write_reg(REG_MAX, 16'd0);
        write_reg(REG_CENTER, 16'd180);
        write_reg(REG_STEP, 16'd0);
        write_reg(REG_STEP_INT, 16'd0);
        write_reg(REG_BLINK, 16'd0);
        write_reg(REG_BEEP, 16'd0);
        write_reg(REG_GAP, 16'd0);
        random_phase(250);
        wait_drained();

        write_reg(REG_MIN, 16'd0);
        write_reg(REG_MAX, 16'd255);
        write_reg(REG_CENTER, 16'd0);
        write_reg(REG_STEP, 16'd255);
        write_reg(REG_STEP_INT, 16'd1);
        write_reg(REG_BLINK, 16'hFFFF);
        write_reg(REG_BEEP, 16'hFFFF);
        write_reg(REG_GAP, 16'd1);
        random_phase(250);
        wait_drained();

        // Narrow window with moderate timing.
        write_reg(REG_MIN, 16'd40);
        write_reg(REG_MAX, 16'd140);
        write_reg(REG_CENTER, 16'd200);
        write_reg(REG_STEP, 16'd3);
        write_reg(REG_STEP_INT, 16'd4);
        write_reg(REG_BLINK, 16'd5);
        write_reg(REG_BEEP, 16'd3);
        write_reg(REG_GAP, 16'd4);
        random_phase(300);
        wait_drained();

        write_reg(REG_CENTER, 16'd90);
        write_reg(REG_STEP, 16'd180);
        write_reg(REG_GAP, 16'hFFFF);
        random_phase(280);

        // Wait for the last items and let the pipeline settle.
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
